### rtl/ftl_pkg.sv
// ----------------------------------------------------------------------------
// ftl_pkg
// Shared types and codes for the queue-to-stack transfer engine.
// ----------------------------------------------------------------------------
package ftl_pkg;

	// fixed field widths on the stream ports
	localparam int IdFieldW    = 16;
	localparam int CountFieldW = 8;
	localparam int CmdW        = 2;
	localparam int StatusW     = 2;

	// command codes carried in the slave tuser
	typedef enum logic [CmdW-1:0] {
		CMD_ARRIVE = 2'd0,
		CMD_ENTER  = 2'd1,
		CMD_EXIT   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	// status codes carried in the master tuser
	typedef enum logic [StatusW-1:0] {
		ST_DONE         = 2'd0,
		ST_QFULL        = 2'd1,
		ST_XFER_REFUSED = 2'd2,
		ST_POP_REFUSED  = 2'd3
	} status_t;

	// controls broadcast to every queue cell
	typedef struct packed {
		logic arrive;   // write the new id at the tail cell
		logic advance;  // every cell takes its upper neighbor's id
	} ftl_q_ctl_t;

	// controls broadcast to every stack cell
	typedef struct packed {
		logic push;     // every cell takes its lower neighbor's id
		logic pop;      // every cell takes its upper neighbor's id
	} ftl_s_ctl_t;

endpackage

### rtl/fifo_to_lifo_transfer_engine_top.sv
// ----------------------------------------------------------------------------
// fifo_to_lifo_transfer_engine_top
// Queue of ids feeding a stack of ids, both built as rows of shifting cells.
// A command's result is registered for the master side in the cycle after it is
// taken. Throughput: one command per cycle unless the master side stalls; every
// command checks only the head and top cells and the two fill counters, and all
// cells shift or load in that cycle. Reset clears both fill counters and the
// output valid; cell contents are not cleared and are only read once written.
// ----------------------------------------------------------------------------
module fifo_to_lifo_transfer_engine_top
	import ftl_pkg::*;
#(
	parameter int DEPTH    = 128,
	parameter int ID_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] item_id
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [7:0] queue_count, [15:8] stack_count,
	                               // [31:16] head_id, [32] head_valid,
	                               // [48:33] top_id, [49] top_valid, [55:50] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]    qfill_q, sfill_q, qfill_n, sfill_n;
	logic [ID_WIDTH-1:0] qdata [DEPTH];
	logic [ID_WIDTH-1:0] sdata [DEPTH];
	ftl_q_ctl_t          q_ctl;
	ftl_s_ctl_t          s_ctl;

	logic                acc;
	cmd_t                cmd;
	logic [ID_WIDTH-1:0] id;
	logic [IdFieldW+ID_WIDTH-1:0] id_ext;
	logic                q_empty, q_full, s_empty, s_full;
	logic                arrive_ok, enter_ok, exit_ok;
	status_t             status;
	logic [ID_WIDTH-1:0] head_raw, top_raw, head_n, top_n;
	logic [ID_WIDTH+IdFieldW-1:0] head_ext, top_ext;
	logic [CNT_W+CountFieldW-1:0] qcnt_ext, scnt_ext;

	logic                m_tvalid_q;
	logic [55:0]         m_tdata_q;
	status_t             m_status_q;

	// input decode
	assign acc     = s_tvalid && s_tready;
	assign cmd     = cmd_t'(s_tuser);
	assign id_ext  = {ID_WIDTH'(0), s_tdata};
	assign id      = id_ext[ID_WIDTH-1:0];

	assign q_empty = (qfill_q == '0);
	assign q_full  = (qfill_q == CNT_W'(DEPTH));
	assign s_empty = (sfill_q == '0);
	assign s_full  = (sfill_q == CNT_W'(DEPTH));

	// command checks against head and top cells
	always_comb begin
		arrive_ok = 1'b0;
		enter_ok  = 1'b0;
		exit_ok   = 1'b0;
		status    = ST_DONE;
		case (cmd)
			CMD_ARRIVE: begin
				arrive_ok = !q_full;
				if (q_full) status = ST_QFULL;
			end
			CMD_ENTER: begin
				enter_ok = !q_empty && (qdata[0] == id) && !s_full;
				if (!enter_ok) status = ST_XFER_REFUSED;
			end
			CMD_EXIT: begin
				exit_ok = !s_empty && (sdata[0] == id);
				if (!exit_ok) status = ST_POP_REFUSED;
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	// cell controls
	assign q_ctl.arrive  = acc && arrive_ok;
	assign q_ctl.advance = acc && enter_ok;
	assign s_ctl.push    = acc && enter_ok;
	assign s_ctl.pop     = acc && exit_ok;

	// fill counters after this command
	always_comb begin
		qfill_n = qfill_q;
		sfill_n = sfill_q;
		if (arrive_ok) qfill_n = qfill_q + 1'b1;
		if (enter_ok) begin
			qfill_n = qfill_q - 1'b1;
			sfill_n = sfill_q + 1'b1;
		end
		if (exit_ok) sfill_n = sfill_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qfill_q <= '0;
			sfill_q <= '0;
		end else if (acc) begin
			qfill_q <= qfill_n;
			sfill_q <= sfill_n;
		end
	end

	// queue cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_qcell
		logic [ID_WIDTH-1:0] upper;
		if (i == DEPTH - 1) begin : g_last
			assign upper = qdata[i];
		end else begin : g_mid
			assign upper = qdata[i+1];
		end
		ftl_queue_cell #(
			.ID_WIDTH (ID_WIDTH),
			.CNT_W    (CNT_W),
			.IDX      (i)
		) u_cell (
			.clk      (clk),
			.ctl      (q_ctl),
			.fill     (qfill_q),
			.new_id   (id),
			.upper_id (upper),
			.id       (qdata[i])
		);
	end

	// stack cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_scell
		logic [ID_WIDTH-1:0] lower, upper;
		if (i == 0) begin : g_first
			assign lower = id;
		end else begin : g_nfirst
			assign lower = sdata[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper = sdata[i];
		end else begin : g_mid
			assign upper = sdata[i+1];
		end
		ftl_stack_cell #(
			.ID_WIDTH (ID_WIDTH)
		) u_cell (
			.clk      (clk),
			.ctl      (s_ctl),
			.lower_id (lower),
			.upper_id (upper),
			.id       (sdata[i])
		);
	end

	// head and top as they stand after this command
	always_comb begin
		if (enter_ok) begin
			head_raw = qdata[1];
		end else if (arrive_ok && q_empty) begin
			head_raw = id;
		end else begin
			head_raw = qdata[0];
		end
		if (enter_ok) begin
			top_raw = id;
		end else if (exit_ok) begin
			top_raw = sdata[1];
		end else begin
			top_raw = sdata[0];
		end
		head_n = (qfill_n != '0) ? head_raw : '0;
		top_n  = (sfill_n != '0) ? top_raw : '0;
	end

	assign head_ext = {IdFieldW'(0), head_n};
	assign top_ext  = {IdFieldW'(0), top_n};
	assign qcnt_ext = {CountFieldW'(0), qfill_n};
	assign scnt_ext = {CountFieldW'(0), sfill_n};

	// output register, refilled when empty or while its transaction is taken
	assign s_tready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			m_status_q <= status;
			m_tdata_q  <= {6'b0,
				(sfill_n != '0), top_ext[IdFieldW-1:0],
				(qfill_n != '0), head_ext[IdFieldW-1:0],
				scnt_ext[CountFieldW-1:0], qcnt_ext[CountFieldW-1:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_status_q;

	// checks
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(qfill_q <= CNT_W'(DEPTH)) && (sfill_q <= CNT_W'(DEPTH)))
		else $error("fill counter beyond depth");

	a_arrive_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd == CMD_ARRIVE && !q_full) |=> (qfill_q == $past(qfill_q) + 1'b1))
		else $error("arrival did not grow the queue");

	a_enter_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && enter_ok) |=> ((qfill_q + sfill_q) == ($past(qfill_q) + $past(sfill_q))))
		else $error("transfer changed total occupancy");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> m_tvalid)
		else $error("accepted command produced no result");

endmodule

### rtl/ftl_queue_cell.sv
// ----------------------------------------------------------------------------
// ftl_queue_cell
// One entry of the shifting queue; the head lives in cell zero.
// ----------------------------------------------------------------------------
module ftl_queue_cell
	import ftl_pkg::*;
#(
	parameter int ID_WIDTH = 16,
	parameter int CNT_W    = 8,
	parameter int IDX      = 0
) (
	input  logic                clk,
	input  ftl_q_ctl_t          ctl,
	input  logic [CNT_W-1:0]    fill,
	input  logic [ID_WIDTH-1:0] new_id,
	input  logic [ID_WIDTH-1:0] upper_id,
	output logic [ID_WIDTH-1:0] id
);

	logic [ID_WIDTH-1:0] id_q;

	// shift toward the head on a transfer, load at the tail on arrival
	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			id_q <= upper_id;
		end else if (ctl.arrive && (fill == CNT_W'(IDX))) begin
			id_q <= new_id;
		end
	end

	assign id = id_q;

endmodule

### rtl/ftl_stack_cell.sv
// ----------------------------------------------------------------------------
// ftl_stack_cell
// One entry of the shifting stack; the top lives in cell zero.
// ----------------------------------------------------------------------------
module ftl_stack_cell
	import ftl_pkg::*;
#(
	parameter int ID_WIDTH = 16
) (
	input  logic                clk,
	input  ftl_s_ctl_t          ctl,
	input  logic [ID_WIDTH-1:0] lower_id,
	input  logic [ID_WIDTH-1:0] upper_id,
	output logic [ID_WIDTH-1:0] id
);

	logic [ID_WIDTH-1:0] id_q;

	// push moves everything one cell deeper, pop one cell back up
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			id_q <= lower_id;
		end else if (ctl.pop) begin
			id_q <= upper_id;
		end
	end

	assign id = id_q;

endmodule

### sim/fifo_to_lifo_transfer_engine_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_to_lifo_transfer_engine_checker
// Watches both stream channels of the transfer engine. Every command taken on
// the slave side is run through a local copy of the queue and stack state, and
// the result it should produce is queued. Every result taken on the master
// side is compared field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module fifo_to_lifo_transfer_engine_checker
	import ftl_pkg::*;
#(
	parameter int DEPTH    = 128,
	parameter int ID_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          fail_count,
	output int          pending,
	output logic [15:0] head_id_now,
	output logic [15:0] top_id_now,
	output int          queue_level,
	output int          stack_level
);

	localparam logic [31:0] IdMask = 32'((64'd1 << ID_WIDTH) - 64'd1);

	typedef struct packed {
		status_t     status;
		logic [7:0]  queue_count;
		logic [7:0]  stack_count;
		logic [15:0] head_id;
		logic        head_valid;
		logic [15:0] top_id;
		logic        top_valid;
		logic [5:0]  pad;
	} engine_result_t;

	// local copy of the engine state
	logic [15:0] q_mem [DEPTH];
	logic [15:0] s_mem [DEPTH];
	int          q_head;
	int          q_fill;
	int          s_fill;

	engine_result_t results_due [$];

	// current head and top, used by the stimulus to build matching commands
	assign head_id_now = (q_fill != 0) ? q_mem[q_head] : '0;
	assign top_id_now  = (s_fill != 0) ? s_mem[s_fill-1] : '0;
	assign queue_level = q_fill;
	assign stack_level = s_fill;

	// apply one command to the state and return the result it produces
	function automatic engine_result_t apply_command(cmd_t c, logic [15:0] raw_id);
		logic [15:0]    id;
		engine_result_t r;
		id       = raw_id & IdMask[15:0];
		r        = '0;
		r.status = ST_DONE;
		case (c)
			CMD_ARRIVE: begin
				if (q_fill >= DEPTH) begin
					r.status = ST_QFULL;
				end else begin
					q_mem[(q_head + q_fill) % DEPTH] = id;
					q_fill++;
				end
			end
			CMD_ENTER: begin
				// a full stack refuses the transfer, nothing is lost
				if (q_fill == 0 || q_mem[q_head] !== id || s_fill >= DEPTH) begin
					r.status = ST_XFER_REFUSED;
				end else begin
					s_mem[s_fill] = id;
					s_fill++;
					q_head = (q_head + 1) % DEPTH;
					q_fill--;
				end
			end
			CMD_EXIT: begin
				if (s_fill == 0 || s_mem[s_fill-1] !== id) begin
					r.status = ST_POP_REFUSED;
				end else begin
					s_fill--;
				end
			end
			default: begin
				// unused code leaves everything alone
			end
		endcase
		r.queue_count = 8'(q_fill);
		r.stack_count = 8'(s_fill);
		if (q_fill != 0) begin
			r.head_id    = q_mem[q_head];
			r.head_valid = 1'b1;
		end
		if (s_fill != 0) begin
			r.top_id    = s_mem[s_fill-1];
			r.top_valid = 1'b1;
		end
		return r;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// result comparison first, then prediction of the newly taken command
	always @(posedge clk or negedge arst_n) begin
		engine_result_t got;
		engine_result_t want;
		if (!arst_n) begin
			q_head = 0;
			q_fill = 0;
			s_fill = 0;
			results_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got.status      = status_t'(m_tuser);
				got.queue_count = m_tdata[7:0];
				got.stack_count = m_tdata[15:8];
				got.head_id     = m_tdata[31:16];
				got.head_valid  = m_tdata[32];
				got.top_id      = m_tdata[48:33];
				got.top_valid   = m_tdata[49];
				got.pad         = m_tdata[55:50];
				if (results_due.size() == 0) begin
					$error("result transaction with nothing expected: tdata 0x%0h tuser %0d",
						m_tdata, m_tuser);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					compare_field("status", want.status, got.status);
					compare_field("queue_count", want.queue_count, got.queue_count);
					compare_field("stack_count", want.stack_count, got.stack_count);
					compare_field("head_id", want.head_id, got.head_id);
					compare_field("head_valid", want.head_valid, got.head_valid);
					compare_field("top_id", want.top_id, got.top_id);
					compare_field("top_valid", want.top_valid, got.top_valid);
					compare_field("tdata padding", want.pad, got.pad);
				end
			end
			if (s_tvalid && s_tready) begin
				results_due.push_back(apply_command(cmd_t'(s_tuser), s_tdata));
			end
		end
		pending = results_due.size();
	end

endmodule

### sim/fifo_to_lifo_transfer_engine_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_to_lifo_transfer_engine_top_test
// Drives commands into the transfer engine: a short directed sequence, runs
// that fill the queue and the stack to their limits and empty them again, then
// a long weighted random mix of matching and mismatching commands. Both sides
// stall in random bursts. The checker beside the engine does all comparison.
// ----------------------------------------------------------------------------
module fifo_to_lifo_transfer_engine_top_test;
	import ftl_pkg::*;

	localparam int Depth       = 128;
	localparam int IdWidth     = 16;
	localparam int QuietLimit  = 2000;
	localparam int StallItems  = 1600;
	localparam int TotalItems  = 1750;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = CMD_NOP;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;

	int          fail_count;
	int          pending;
	logic [15:0] head_id_now;
	logic [15:0] top_id_now;
	int          queue_level;
	int          stack_level;

	bit          stalls_on   = 1'b1;
	int          items_sent  = 0;
	int          stall_left  = 0;
	int          quiet_cycles = 0;

	fifo_to_lifo_transfer_engine_top #(
		.DEPTH    (Depth),
		.ID_WIDTH (IdWidth)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	fifo_to_lifo_transfer_engine_checker #(
		.DEPTH    (Depth),
		.ID_WIDTH (IdWidth)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.pending     (pending),
		.head_id_now (head_id_now),
		.top_id_now  (top_id_now),
		.queue_level (queue_level),
		.stack_level (stack_level)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver backpressure in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (stalls_on && $urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(1, 18) - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QuietLimit) begin
			$display("fifo_to_lifo_transfer_engine_top_test NOT OK");
			$finish;
		end
	end

	// ids biased toward the all-zero and all-one extremes
	function automatic logic [15:0] pick_id();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 16'h0000;
		end else if (r == 1) begin
			return 16'hFFFF;
		end
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	// one command transaction, called and returning at a falling edge
	task automatic send_cmd(input cmd_t c, input logic [15:0] id);
		if (stalls_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= id;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	// hold off until every result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// one weighted random command, mostly ones that match head or top
	task automatic mixed_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 32) begin
			send_cmd(CMD_ARRIVE, pick_id());
		end else if (r < 60) begin
			send_cmd(CMD_ENTER, head_id_now);
		end else if (r < 85) begin
			send_cmd(CMD_EXIT, top_id_now);
		end else if (r < 91) begin
			send_cmd(CMD_ENTER, head_id_now ^ (16'h1 << $urandom_range(0, 15)));
		end else if (r < 96) begin
			send_cmd(CMD_EXIT, top_id_now ^ (16'h1 << $urandom_range(0, 15)));
		end else begin
			send_cmd(cmd_t'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: refusals on empty, unused code, matches and mismatches
		send_cmd(CMD_EXIT, 16'h0000);
		send_cmd(CMD_ENTER, 16'h0000);
		send_cmd(CMD_NOP, 16'hFFFF);
		send_cmd(CMD_ARRIVE, 16'hFFFF);
		send_cmd(CMD_ARRIVE, 16'h0000);
		send_cmd(CMD_ARRIVE, 16'hA5A5);
		send_cmd(CMD_ENTER, 16'h1234);
		send_cmd(CMD_ENTER, 16'h7FFF);
		send_cmd(CMD_ENTER, 16'hFFFF);
		send_cmd(CMD_EXIT, 16'h0000);
		send_cmd(CMD_EXIT, 16'hFFFF);
		send_cmd(CMD_ENTER, 16'h0000);
		send_cmd(CMD_ENTER, 16'hA5A5);
		send_cmd(CMD_NOP, 16'h5A5A);
		send_cmd(CMD_EXIT, 16'hA5A4);
		send_cmd(CMD_EXIT, 16'hA5A5);
		send_cmd(CMD_EXIT, 16'h0000);
		send_cmd(CMD_EXIT, 16'h0000);
		send_cmd(CMD_ENTER, 16'h0000);
		drain();

		// fill the queue and overflow it
		while (queue_level < Depth) send_cmd(CMD_ARRIVE, pick_id());
		repeat (3) send_cmd(CMD_ARRIVE, pick_id());

		// move everything onto the stack, then hit the full stack
		while (queue_level > 0 && stack_level < Depth) send_cmd(CMD_ENTER, head_id_now);
		send_cmd(CMD_ENTER, head_id_now);
		send_cmd(CMD_ARRIVE, pick_id());
		send_cmd(CMD_ARRIVE, pick_id());
		send_cmd(CMD_ENTER, head_id_now);
		drain();

		// both full, then unwind the stack
		while (queue_level < Depth) send_cmd(CMD_ARRIVE, pick_id());
		send_cmd(CMD_ARRIVE, pick_id());
		send_cmd(CMD_ENTER, head_id_now);
		send_cmd(CMD_EXIT, top_id_now ^ 16'h8000);
		while (stack_level > 0) send_cmd(CMD_EXIT, top_id_now);
		send_cmd(CMD_EXIT, top_id_now);

		// weighted random mix with stretches of stalls and of none
		while (items_sent < StallItems) begin
			if (items_sent % 100 == 0) stalls_on = ($urandom_range(0, 3) != 0);
			mixed_cmd();
		end
		stalls_on = 1'b0;
		while (items_sent < TotalItems) mixed_cmd();

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("fifo_to_lifo_transfer_engine_top_test OK");
		end else begin
			$display("fifo_to_lifo_transfer_engine_top_test NOT OK");
		end
		$finish;
	end

endmodule
